[src/pmst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_pkg: shared types and constants of the pixel marker stability tracker
// Record layout of one pixel's history, beat types and register codes.
// ----------------------------------------------------------------------------
package pmst_pkg;

    localparam int PIXEL_COUNT_DEF = 65536;

    localparam int IDX_IN_W = 16;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int CLS_W    = 3;
    localparam int CRC_W    = 32;
    localparam int DRIFT_W  = 10;
    localparam int TOTAL_W  = 32;
    localparam int CFG_W    = 10;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'h0101_0101;

    localparam logic [CHAN_W-1:0]  RST_THRESHOLD = 8'd128;
    localparam logic [CHAN_W-1:0]  RST_DARK      = 8'd5;
    localparam logic [CHAN_W-1:0]  RST_BRIGHT    = 8'd250;
    localparam logic [DRIFT_W-1:0] RST_DRIFT     = 10'd32;

    localparam logic [CLS_W-1:0] CLS_BLACK = 3'd0;
    localparam logic [CLS_W-1:0] CLS_WHITE = 3'd7;

    typedef enum logic [1:0] {
        CFG_COLOR_THRESHOLD,
        CFG_DARK_MARGIN,
        CFG_BRIGHT_MARGIN,
        CFG_DRIFT_LIMIT
    } cfg_reg_t;

    // One pixel beat: raster index and color (red in the top byte).
    typedef struct packed {
        logic [IDX_IN_W-1:0] idx;
        logic [COLOR_W-1:0]  color;
    } beat_t;

    // Per-pixel facts that do not depend on stored history.
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             unsat;
    } px_info_t;

    // Full history of one pixel, one memory word.
    typedef struct packed {
        logic               good;
        logic               mono;
        logic [COLOR_W-1:0] ch_min;
        logic [COLOR_W-1:0] ch_max;
        logic [CRC_W-1:0]   crc;
        logic [CLS_W-1:0]   anchor_cls;
        logic [COLOR_W-1:0] anchor_color;
        logic [COLOR_W-1:0] prev_color;
        logic [TOTAL_W-1:0] total;
    } pix_rec_t;

    localparam int REC_W = $bits(pix_rec_t);

    localparam pix_rec_t REC_RESET = '{
        good:         1'b1,
        mono:         1'b1,
        ch_min:       24'hFF_FFFF,
        ch_max:       24'h00_0000,
        crc:          CRC_INIT,
        anchor_cls:   CLS_BLACK,
        anchor_color: 24'h00_0000,
        prev_color:   24'h00_0000,
        total:        32'h0000_0000
    };

endpackage
`default_nettype wire

[src/pmst_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module pmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[src/pmst_index_wrap.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_index_wrap: two-stage front end that folds the raster index
// Reduce the index modulo the store depth by reciprocal multiplication,
// quotient in the first stage, remainder in the second.
// ----------------------------------------------------------------------------
module pmst_index_wrap #(
    parameter int PIXEL_COUNT = pmst_pkg::PIXEL_COUNT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            accept,
    input  wire pmst_pkg::beat_t raw,
    output logic                 out_valid,
    output pmst_pkg::beat_t      out_beat
);

    logic            pa_valid_reg;
    logic            pb_valid_reg;
    pmst_pkg::beat_t pa_beat_reg;
    pmst_pkg::beat_t pb_beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_valid_reg <= 1'b0;
            pb_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pa_valid_reg <= accept;
            pb_valid_reg <= pa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_beat_reg <= raw;
            pb_beat_reg <= pa_beat_reg;
        end
    end

    generate
        if (PIXEL_COUNT >= (1 << pmst_pkg::IDX_IN_W))
        begin : g_pass
            // every index already lies inside the store
            assign out_beat = pb_beat_reg;
        end
        else
        begin : g_wrap
            localparam logic [63:0] RECIP_L =
                ((64'd1 << 32) + 64'(PIXEL_COUNT) - 64'd1) / 64'(PIXEL_COUNT);
            localparam logic [32:0] RECIP = RECIP_L[32:0];
            localparam logic [16:0] COUNT = 17'(PIXEL_COUNT);

            logic [48:0] prod;
            logic [15:0] quot_reg;
            logic [32:0] back;
            logic [16:0] rem;

            // ceil(2^32/N) is exact for 16-bit indexes
            assign prod = 49'(pa_beat_reg.idx) * 49'(RECIP);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    quot_reg <= prod[47:32];
                end
            end

            assign back = 33'(quot_reg) * 33'(COUNT);
            assign rem  = {1'b0, pb_beat_reg.idx} - back[16:0];

            always_comb
            begin
                out_beat     = pb_beat_reg;
                out_beat.idx = rem[15:0];
            end
        end
    endgenerate

    assign out_valid = pb_valid_reg;

endmodule
`default_nettype wire

[src/pmst_rec_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_rec_update: history update of one pixel
// Fold one pixel into its stored record: min/max, class CRC, black/white
// flag, drift test, and the frame-to-frame change total.
// ----------------------------------------------------------------------------
module pmst_rec_update (
    input  wire pmst_pkg::pix_rec_t       old_rec,
    input  wire logic [pmst_pkg::COLOR_W-1:0] color,
    input  wire pmst_pkg::px_info_t       info,
    input  wire logic [pmst_pkg::DRIFT_W-1:0] drift_limit,
    output pmst_pkg::pix_rec_t            new_rec
);

    function automatic logic [pmst_pkg::CRC_W-1:0] crc_byte(
        input logic [pmst_pkg::CRC_W-1:0] crc,
        input logic [pmst_pkg::CLS_W-1:0] cls
    );
        logic [pmst_pkg::CRC_W-1:0] c;
        c = ~crc ^ pmst_pkg::CRC_W'(cls);
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ pmst_pkg::CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

    function automatic logic [pmst_pkg::CHAN_W-1:0] absdiff(
        input logic [pmst_pkg::CHAN_W-1:0] a,
        input logic [pmst_pkg::CHAN_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    localparam int CW = pmst_pkg::CHAN_W;

    always_comb
    begin
        logic [pmst_pkg::DRIFT_W-1:0] drift;
        logic [pmst_pkg::DRIFT_W-1:0] change;
        logic [CW-1:0]                px;

        new_rec = old_rec;
        drift   = '0;
        change  = '0;

        for (int l = 0; l < 3; l++)
        begin
            px     = color[CW*l +: CW];
            drift  = drift + pmst_pkg::DRIFT_W'(absdiff(px, old_rec.anchor_color[CW*l +: CW]));
            change = change + pmst_pkg::DRIFT_W'(absdiff(px, old_rec.prev_color[CW*l +: CW]));
            if (old_rec.good && (px < old_rec.ch_min[CW*l +: CW]))
            begin
                new_rec.ch_min[CW*l +: CW] = px;
            end
            if (old_rec.good && (px > old_rec.ch_max[CW*l +: CW]))
            begin
                new_rec.ch_max[CW*l +: CW] = px;
            end
        end

        if (old_rec.good)
        begin
            new_rec.crc = crc_byte(old_rec.crc, info.cls);
            if ((info.cls != pmst_pkg::CLS_BLACK) && (info.cls != pmst_pkg::CLS_WHITE))
            begin
                new_rec.mono = 1'b0;
            end
            if (info.unsat)
            begin
                new_rec.good = 1'b0;
            end
            // re-anchor on a class change, otherwise test the drift
            if (old_rec.anchor_cls != info.cls)
            begin
                new_rec.anchor_cls   = info.cls;
                new_rec.anchor_color = color;
            end
            else if (drift > drift_limit)
            begin
                new_rec.good = 1'b0;
            end
        end

        new_rec.prev_color = color;
        new_rec.total      = old_rec.total + pmst_pkg::TOTAL_W'(change);
    end

endmodule
`default_nettype wire

[src/pixel_marker_stability_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_marker_stability_tracker: per-pixel marker history across frames
// Streams RGB pixels, updates each pixel's stored history in place and
// returns its filtered CRC signature and change total.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while out_ready stays high and no clearing
// sweep runs, and returns one result beat per pixel, in order. A pixel passes
// two stages that fold the index into the store, one that reads the history
// memory, one that updates the record and one that forms the signature, then
// the output register; the sustained rate is one pixel per clock, set by the
// single read and single write port of the history memory. Back-to-back
// pixels at the same index are handled by forwarding the two most recent
// updates around the memory. After reset the block sweeps the history memory
// to its initial contents, one entry per clock; in_ready stays low during the
// sweep while configuration writes are taken at once. Raster indexes wrap
// modulo PIXEL_COUNT and out_index reports the wrapped index. Write
// configuration only while no pixel is in flight.
// ----------------------------------------------------------------------------
module pixel_marker_stability_tracker #(
    parameter int PIXEL_COUNT = pmst_pkg::PIXEL_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pmst_pkg::IDX_IN_W-1:0] pixel_index,
    input  wire logic [pmst_pkg::CHAN_W-1:0]   red,
    input  wire logic [pmst_pkg::CHAN_W-1:0]   green,
    input  wire logic [pmst_pkg::CHAN_W-1:0]   blue,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [pmst_pkg::IDX_IN_W-1:0]      out_index,
    output logic                               still_good,
    output logic                               black_white,
    output logic [pmst_pkg::CRC_W-1:0]         signature,
    output logic [pmst_pkg::TOTAL_W-1:0]       change_sum,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [pmst_pkg::CFG_W-1:0]    cfg_data
);

    localparam int IDX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PIXEL_COUNT - 1);
    localparam int CW = pmst_pkg::CHAN_W;

    // ---------------------------------------------------------------- control
    // The whole pipeline moves together whenever the output register can take
    // a beat; bubbles travel as cleared valid bits.
    logic adv;
    logic accept;

    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv && !clr_busy_reg;
    assign accept   = in_valid && in_ready;

    // ---------------------------------------------------------- configuration
    logic [CW-1:0]                 thr_reg;
    logic [CW-1:0]                 dark_reg;
    logic [CW-1:0]                 bright_reg;
    logic [pmst_pkg::DRIFT_W-1:0]  drift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= pmst_pkg::RST_THRESHOLD;
            dark_reg   <= pmst_pkg::RST_DARK;
            bright_reg <= pmst_pkg::RST_BRIGHT;
            drift_reg  <= pmst_pkg::RST_DRIFT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pmst_pkg::cfg_reg_t'(cfg_index))
                pmst_pkg::CFG_COLOR_THRESHOLD: thr_reg    <= cfg_data[CW-1:0];
                pmst_pkg::CFG_DARK_MARGIN:     dark_reg   <= cfg_data[CW-1:0];
                pmst_pkg::CFG_BRIGHT_MARGIN:   bright_reg <= cfg_data[CW-1:0];
                pmst_pkg::CFG_DRIFT_LIMIT:     drift_reg  <= cfg_data;
            endcase
        end
    end

    // -------------------------------------------------------- clearing sweep
    // Walk the history memory once after reset, writing the initial record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------ index front end
    pmst_pkg::beat_t raw_beat;
    pmst_pkg::beat_t wrap_beat;
    logic            wrap_valid;

    assign raw_beat.idx   = pixel_index;
    assign raw_beat.color = {red, green, blue};

    pmst_index_wrap #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_index_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .accept    (accept),
        .raw       (raw_beat),
        .out_valid (wrap_valid),
        .out_beat  (wrap_beat)
    );

    // ----------------------------------------------------- history memory
    pmst_pkg::pix_rec_t ram_rdata;
    logic [pmst_pkg::REC_W-1:0] ram_rdata_raw;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    pmst_pkg::pix_rec_t         ram_wdata;

    logic                 s1_valid_reg;
    pmst_pkg::beat_t      s1_beat_reg;
    logic                 s2_valid_reg;
    pmst_pkg::beat_t      s2_beat_reg;
    pmst_pkg::px_info_t   s2_info_reg;
    pmst_pkg::pix_rec_t   s2_old_reg;
    pmst_pkg::pix_rec_t   s2_new;
    logic                 s3_valid_reg;
    logic [pmst_pkg::IDX_IN_W-1:0] s3_idx_reg;
    pmst_pkg::pix_rec_t   s3_rec_reg;

    // The updated record is written as it leaves the update stage.
    assign ram_we    = clr_busy_reg || (adv && s2_valid_reg);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : IDX_W'(s2_beat_reg.idx);
    assign ram_wdata = clr_busy_reg ? pmst_pkg::REC_RESET : s2_new;
    assign ram_rdata = pmst_pkg::pix_rec_t'(ram_rdata_raw);

    pmst_ram #(
        .WIDTH (pmst_pkg::REC_W),
        .DEPTH (PIXEL_COUNT)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (IDX_W'(wrap_beat.idx)),
        .rdata (ram_rdata_raw)
    );

    // ------------------------------------------------------ stage 1: read
    // Classify the pixel and pick the freshest copy of its record: the update
    // in flight wins, then the one just written, then the memory.
    pmst_pkg::px_info_t s1_info;
    pmst_pkg::pix_rec_t s1_old;

    always_comb
    begin
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;

        r  = s1_beat_reg.color[2*CW +: CW];
        g  = s1_beat_reg.color[CW +: CW];
        b  = s1_beat_reg.color[0 +: CW];
        lo = (r < g) ? r : g;
        lo = (b < lo) ? b : lo;
        hi = (r > g) ? r : g;
        hi = (b > hi) ? b : hi;

        s1_info.cls   = {b > thr_reg, g > thr_reg, r > thr_reg};
        s1_info.unsat = (lo > dark_reg) && (hi < bright_reg);

        if (s2_valid_reg && (s2_beat_reg.idx == s1_beat_reg.idx))
        begin
            s1_old = s2_new;
        end
        else if (s3_valid_reg && (s3_idx_reg == s1_beat_reg.idx))
        begin
            s1_old = s3_rec_reg;
        end
        else
        begin
            s1_old = ram_rdata;
        end
    end

    // ---------------------------------------------------- stage 2: update
    pmst_rec_update u_rec_update (
        .old_rec     (s2_old_reg),
        .color       (s2_beat_reg.color),
        .info        (s2_info_reg),
        .drift_limit (drift_reg),
        .new_rec     (s2_new)
    );

    // ------------------------------------------------- stage 3: signature
    // Hide the signature of ruled-out pixels and of pixels flat in any channel;
    // show a stored zero CRC as one.
    logic [pmst_pkg::CRC_W-1:0] s3_sig;

    always_comb
    begin
        s3_sig = (s3_rec_reg.crc == '0) ? pmst_pkg::CRC_W'(1) : s3_rec_reg.crc;
        if (!s3_rec_reg.good)
        begin
            s3_sig = '0;
        end
        for (int l = 0; l < 3; l++)
        begin
            if (s3_rec_reg.ch_min[CW*l +: CW] == s3_rec_reg.ch_max[CW*l +: CW])
            begin
                s3_sig = '0;
            end
        end
    end

    // ------------------------------------------------------ pipeline regs
    logic                          out_valid_reg;
    logic [pmst_pkg::IDX_IN_W-1:0] out_idx_reg;
    logic                          out_good_reg;
    logic                          out_mono_reg;
    logic [pmst_pkg::CRC_W-1:0]    out_sig_reg;
    logic [pmst_pkg::TOTAL_W-1:0]  out_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= wrap_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_beat_reg   <= wrap_beat;
            s2_beat_reg   <= s1_beat_reg;
            s2_info_reg   <= s1_info;
            s2_old_reg    <= s1_old;
            s3_idx_reg    <= s2_beat_reg.idx;
            s3_rec_reg    <= s2_new;
            out_idx_reg   <= s3_idx_reg;
            out_good_reg  <= s3_rec_reg.good;
            out_mono_reg  <= s3_rec_reg.mono;
            out_sig_reg   <= s3_sig;
            out_total_reg <= s3_rec_reg.total;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_idx_reg;
    assign still_good  = out_good_reg;
    assign black_white = out_mono_reg;
    assign signature   = out_sig_reg;
    assign change_sum  = out_total_reg;

    // ------------------------------------------------------------ checks
    // No pixel may be in flight while the sweep owns the memory.
    a_sweep_alone: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !(s1_valid_reg || s2_valid_reg || s3_valid_reg))
        else $error("pixel in flight during clearing sweep");

    // A ruled-out pixel never comes back.
    a_good_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s2_valid_reg && !s2_old_reg.good |=> !s3_rec_reg.good)
        else $error("ruled-out pixel became good again");

    // A nonzero signature belongs to a good pixel only.
    a_sig_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (signature != '0) |-> still_good)
        else $error("nonzero signature on a ruled-out pixel");

endmodule
`default_nettype wire
